// ===== sv/trq_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch report qualifier package
// Shared widths, codes and reset values for the touch report qualifier.
// ----------------------------------------------------------------------------
package trq_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned US_W    = 16;
  localparam int unsigned DELAY_W = 10;
  localparam int unsigned FAIL_W  = 8;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned BUF_W   = 16;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 5;

  localparam logic [BUF_W-1:0]   REPORT_BYTES        = BUF_W'(6);
  localparam logic [DELAY_W-1:0] RELEASE_DELAY_RESET = DELAY_W'(20);
  localparam logic [US_W-1:0]    POLL_MIN_RESET      = US_W'(8000);
  localparam logic [US_W-1:0]    POLL_MAX_RESET      = US_W'(50000);
  localparam logic [US_W-1:0]    POLL_HOLD_RESET     = US_W'(2000);
  localparam logic [FAIL_W-1:0]  FAIL_LIMIT_RESET    = FAIL_W'(20);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TOUCH = 2'd1,
    MODE_HOST  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_NOT_READ  = 2'd0,
    STATUS_DELIVERED = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_TOO_SMALL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_RELEASE_DELAY = 3'd0,
    REG_POLL_MIN      = 3'd1,
    REG_POLL_MAX      = 3'd2,
    REG_POLL_HOLD     = 3'd3,
    REG_FAIL_LIMIT    = 3'd4
  } reg_idx_t;

endpackage

// ===== sv/trq_req_if.sv =====
// ----------------------------------------------------------------------------
// Touch report qualifier request channel
// Carries one poll, touch read or host read beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface trq_req_if;
  logic                           valid;
  logic                           ready;
  trq_pkg::mode_t                 mode;
  logic [trq_pkg::TIME_W-1:0]     now_ms;
  logic                           read_ok;
  logic [trq_pkg::COUNT_W-1:0]    point_count;
  logic [trq_pkg::COORD_W-1:0]    point_x;
  logic [trq_pkg::COORD_W-1:0]    point_y;
  logic [trq_pkg::BUF_W-1:0]      buf_size;

  modport source (
    output valid, mode, now_ms, read_ok, point_count, point_x, point_y, buf_size,
    input  ready
  );
  modport sink (
    input  valid, mode, now_ms, read_ok, point_count, point_x, point_y, buf_size,
    output ready
  );
endinterface

// ===== sv/trq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Touch report qualifier result channel
// Carries one result beat per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface trq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [trq_pkg::US_W-1:0]    sleep_us;
  logic                        wakeup;
  logic                        reinit_request;
  trq_pkg::status_t            read_status;
  logic                        read_press;
  logic [trq_pkg::COORD_W-1:0] read_x;
  logic [trq_pkg::COORD_W-1:0] read_y;
  logic                        report_ready;

  modport source (
    output valid, sleep_us, wakeup, reinit_request, read_status, read_press,
           read_x, read_y, report_ready,
    input  ready
  );
  modport sink (
    input  valid, sleep_us, wakeup, reinit_request, read_status, read_press,
           read_x, read_y, report_ready,
    output ready
  );
endinterface

// ===== sv/touch_report_qualifier.sv =====
// ----------------------------------------------------------------------------
// Touch report qualifier
// Turns touch controller readings into press and release reports in a
// one-slot mailbox and chooses the wait before the next poll.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock and returns its result beat in
// the output register on the following cycle; all state is updated in the
// same edge that accepts the request, so back-to-back beats see each other's
// effects. The request side stalls only while the output register holds a
// result that the sink has not taken. Registers must be written over the APB
// port only while no request is in flight; the block does not enforce this.
module touch_report_qualifier (
  input  logic                        clk,
  input  logic                        rst,
  trq_req_if.sink                     req,
  trq_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trq_pkg::APB_AW-1:0]  paddr,
  input  logic [trq_pkg::APB_DW-1:0]  pwdata,
  output logic [trq_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import trq_pkg::*;

  // Configuration registers.
  logic [DELAY_W-1:0] release_delay_ms;
  logic [US_W-1:0]    poll_min_us;
  logic [US_W-1:0]    poll_max_us;
  logic [US_W-1:0]    poll_hold_us;
  logic [FAIL_W-1:0]  fail_limit;

  // Block state.
  logic               pressed,        pressed_next;
  logic [TIME_W-1:0]  last_touch_ms,  last_touch_ms_next;
  logic               report_press,   report_press_next;
  logic [COORD_W-1:0] report_x,       report_x_next;
  logic [COORD_W-1:0] report_y,       report_y_next;
  logic               report_pending, report_pending_next;
  logic [US_W-1:0]    poll_interval,  poll_interval_next;
  logic [FAIL_W-1:0]  fail_count,     fail_count_next;
  logic [COORD_W-1:0] last_x,         last_x_next;
  logic [COORD_W-1:0] last_y,         last_y_next;

  // Result fields before the output register.
  logic [US_W-1:0]    res_sleep;
  logic               res_wake;
  logic               res_reinit;
  status_t            res_status;
  logic               res_press;
  logic [COORD_W-1:0] res_x;
  logic [COORD_W-1:0] res_y;

  logic               req_fire;
  logic               cfg_write;
  reg_idx_t           cfg_idx;
  logic [TIME_W-1:0]  elapsed;
  logic               release_due;
  logic [US_W:0]      poll_doubled;
  logic [US_W-1:0]    poll_backoff;
  logic [FAIL_W-1:0]  fail_inc;

  assign req.ready = !rsp.valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[APB_AW-1:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_RELEASE_DELAY: prdata = APB_DW'(release_delay_ms);
      REG_POLL_MIN:      prdata = APB_DW'(poll_min_us);
      REG_POLL_MAX:      prdata = APB_DW'(poll_max_us);
      REG_POLL_HOLD:     prdata = APB_DW'(poll_hold_us);
      REG_FAIL_LIMIT:    prdata = APB_DW'(fail_limit);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      release_delay_ms <= RELEASE_DELAY_RESET;
      poll_min_us      <= POLL_MIN_RESET;
      poll_max_us      <= POLL_MAX_RESET;
      poll_hold_us     <= POLL_HOLD_RESET;
      fail_limit       <= FAIL_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_RELEASE_DELAY: release_delay_ms <= pwdata[DELAY_W-1:0];
        REG_POLL_MIN:      poll_min_us      <= pwdata[US_W-1:0];
        REG_POLL_MAX:      poll_max_us      <= pwdata[US_W-1:0];
        REG_POLL_HOLD:     poll_hold_us     <= pwdata[US_W-1:0];
        REG_FAIL_LIMIT:    fail_limit       <= pwdata[FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  assign elapsed      = req.now_ms - last_touch_ms;
  assign release_due  = pressed && (elapsed > TIME_W'(release_delay_ms));
  assign poll_doubled = {poll_interval, 1'b0};
  assign fail_inc     = fail_count + FAIL_W'(1);

  always_comb begin
    if (poll_interval < poll_max_us) begin
      poll_backoff = (poll_doubled > {1'b0, poll_max_us}) ? poll_max_us
                                                           : poll_doubled[US_W-1:0];
    end else begin
      poll_backoff = poll_interval;
    end
  end

  always_comb begin
    pressed_next        = pressed;
    last_touch_ms_next  = last_touch_ms;
    report_press_next   = report_press;
    report_x_next       = report_x;
    report_y_next       = report_y;
    report_pending_next = report_pending;
    poll_interval_next  = poll_interval;
    fail_count_next     = fail_count;
    last_x_next         = last_x;
    last_y_next         = last_y;
    res_sleep           = '0;
    res_wake            = 1'b0;
    res_reinit          = 1'b0;
    res_status          = STATUS_NOT_READ;
    res_press           = 1'b0;
    res_x               = '0;
    res_y               = '0;

    unique case (req.mode)
      MODE_IDLE: begin
        if (release_due) begin
          pressed_next        = 1'b0;
          report_press_next   = 1'b0;
          report_x_next       = last_x;
          report_y_next       = last_y;
          report_pending_next = 1'b1;
          res_wake            = !report_pending;
        end
        if (res_wake) begin
          poll_interval_next = poll_min_us;
          res_sleep          = poll_min_us;
        end else if (pressed && !release_due) begin
          res_sleep = poll_hold_us;
        end else begin
          poll_interval_next = poll_backoff;
          res_sleep          = poll_backoff;
        end
      end
      MODE_TOUCH: begin
        if (req.read_ok) begin
          fail_count_next = '0;
          last_x_next     = req.point_x;
          last_y_next     = req.point_y;
        end else if (fail_inc >= fail_limit) begin
          fail_count_next = '0;
          res_reinit      = 1'b1;
        end else begin
          fail_count_next = fail_inc;
        end
        if (!req.read_ok || req.point_count == '0) begin
          if (release_due) begin
            pressed_next        = 1'b0;
            report_press_next   = 1'b0;
            report_x_next       = last_x_next;
            report_y_next       = last_y_next;
            report_pending_next = 1'b1;
            res_wake            = !report_pending;
          end
        end else begin
          last_touch_ms_next  = req.now_ms;
          pressed_next        = 1'b1;
          report_press_next   = 1'b1;
          report_x_next       = req.point_x;
          report_y_next       = req.point_y;
          report_pending_next = 1'b1;
          res_wake            = !report_pending;
        end
        poll_interval_next = res_wake ? poll_min_us : poll_backoff;
        res_sleep          = poll_interval_next;
      end
      MODE_HOST: begin
        if (!report_pending) begin
          res_status = STATUS_EMPTY;
        end else if (req.buf_size < REPORT_BYTES) begin
          res_status = STATUS_TOO_SMALL;
        end else begin
          res_status          = STATUS_DELIVERED;
          res_press           = report_press;
          res_x               = report_x;
          res_y               = report_y;
          report_pending_next = 1'b0;
        end
      end
      MODE_NONE: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed        <= 1'b0;
      last_touch_ms  <= '0;
      report_press   <= 1'b0;
      report_x       <= '0;
      report_y       <= '0;
      report_pending <= 1'b0;
      poll_interval  <= POLL_MIN_RESET;
      fail_count     <= '0;
      last_x         <= '0;
      last_y         <= '0;
    end else if (req_fire) begin
      pressed        <= pressed_next;
      last_touch_ms  <= last_touch_ms_next;
      report_press   <= report_press_next;
      report_x       <= report_x_next;
      report_y       <= report_y_next;
      report_pending <= report_pending_next;
      poll_interval  <= poll_interval_next;
      fail_count     <= fail_count_next;
      last_x         <= last_x_next;
      last_y         <= last_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp.sleep_us       <= res_sleep;
      rsp.wakeup         <= res_wake;
      rsp.reinit_request <= res_reinit;
      rsp.read_status    <= res_status;
      rsp.read_press     <= res_press;
      rsp.read_x         <= res_x;
      rsp.read_y         <= res_y;
      rsp.report_ready   <= report_pending_next;
    end
  end

endmodule

// ===== sv/trq_checker.sv =====
// ----------------------------------------------------------------------------
// Touch report qualifier checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module trq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [trq_pkg::US_W-1:0]    sleep_us,
  input logic                        wakeup,
  input logic                        reinit_request,
  input trq_pkg::status_t            read_status,
  input logic                        report_ready
);
  import trq_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result beat valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(sleep_us) && $stable(read_status))
    else $error("stalled result beat changed");

  a_wake_pending: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && wakeup |-> report_ready)
    else $error("wakeup without a pending report");

  a_deliver_clears: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && read_status == STATUS_DELIVERED |-> !report_ready)
    else $error("report still pending after delivery");

  a_host_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && read_status != STATUS_NOT_READ |->
      sleep_us == '0 && !wakeup && !reinit_request)
    else $error("host read beat carries poll fields");

endmodule

bind touch_report_qualifier trq_checker u_trq_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .sleep_us       (rsp.sleep_us),
  .wakeup         (rsp.wakeup),
  .reinit_request (rsp.reinit_request),
  .read_status    (rsp.read_status),
  .report_ready   (rsp.report_ready)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch report qualifier testbench
// Drives poll, touch read and host read beats through the request channel and
// checks every result beat against a cycle-free predictor of the mailbox,
// release timing, poll interval and failure counting. Runs several register
// settings, extremes included, mostly with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import trq_pkg::*;

  typedef struct packed {
    mode_t              mode;
    logic [TIME_W-1:0]  now_ms;
    logic               read_ok;
    logic [COUNT_W-1:0] point_count;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [BUF_W-1:0]   buf_size;
  } beat_t;

  typedef struct packed {
    logic [US_W-1:0]    sleep_us;
    logic               wakeup;
    logic               reinit_request;
    status_t            read_status;
    logic               read_press;
    logic [COORD_W-1:0] read_x;
    logic [COORD_W-1:0] read_y;
    logic               report_ready;
  } outcome_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  trq_req_if req ();
  trq_rsp_if rsp ();

  touch_report_qualifier u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  beat_t    request_queue[$];
  outcome_t awaited_outcomes[$];
  beat_t    shown_beat;
  int       errors = 0;
  int       queued = 0;
  bit       calm = 1'b0;
  logic [TIME_W-1:0] stim_ms = '0;

  logic [DELAY_W-1:0] cfg_delay = RELEASE_DELAY_RESET;
  logic [US_W-1:0]    cfg_min   = POLL_MIN_RESET;
  logic [US_W-1:0]    cfg_max   = POLL_MAX_RESET;
  logic [US_W-1:0]    cfg_hold  = POLL_HOLD_RESET;
  logic [FAIL_W-1:0]  cfg_limit = FAIL_LIMIT_RESET;

  logic               pressed;
  logic [TIME_W-1:0]  last_touch_ms;
  logic               rep_press;
  logic [COORD_W-1:0] rep_x;
  logic [COORD_W-1:0] rep_y;
  logic               rep_pending;
  logic [US_W-1:0]    poll_gap_us;
  logic [FAIL_W-1:0]  fail_count;
  logic [COORD_W-1:0] last_x;
  logic [COORD_W-1:0] last_y;

  function automatic logic post_report(logic press);
    logic fresh;
    fresh = !rep_pending;
    rep_press = press;
    rep_x = last_x;
    rep_y = last_y;
    rep_pending = 1'b1;
    return fresh;
  endfunction

  function automatic logic release_due(logic [TIME_W-1:0] now_ms);
    logic [TIME_W-1:0] idle_ms;
    idle_ms = now_ms - last_touch_ms;
    if (pressed && idle_ms > TIME_W'(cfg_delay)) begin
      pressed = 1'b0;
      return post_report(1'b0);
    end
    return 1'b0;
  endfunction

  function automatic void back_off();
    logic [US_W:0] twice;
    if (poll_gap_us < cfg_max) begin
      twice = {poll_gap_us, 1'b0};
      if (twice > {1'b0, cfg_max}) twice = {1'b0, cfg_max};
      poll_gap_us = twice[US_W-1:0];
    end
  endfunction

  function automatic outcome_t qualify(beat_t b);
    outcome_t o;
    o = '0;
    case (b.mode)
      MODE_IDLE: begin
        o.wakeup = release_due(b.now_ms);
        if (o.wakeup) begin
          poll_gap_us = cfg_min;
          o.sleep_us = poll_gap_us;
        end else if (pressed) begin
          o.sleep_us = cfg_hold;
        end else begin
          back_off();
          o.sleep_us = poll_gap_us;
        end
      end
      MODE_TOUCH: begin
        if (b.read_ok) begin
          fail_count = '0;
          last_x = b.point_x;
          last_y = b.point_y;
        end else begin
          fail_count = fail_count + FAIL_W'(1);
          if (fail_count >= cfg_limit) begin
            fail_count = '0;
            o.reinit_request = 1'b1;
          end
        end
        if (!b.read_ok || b.point_count == '0) begin
          o.wakeup = release_due(b.now_ms);
        end else begin
          last_touch_ms = b.now_ms;
          pressed = 1'b1;
          o.wakeup = post_report(1'b1);
        end
        if (o.wakeup) poll_gap_us = cfg_min;
        else back_off();
        o.sleep_us = poll_gap_us;
      end
      MODE_HOST: begin
        if (!rep_pending) begin
          o.read_status = STATUS_EMPTY;
        end else if (b.buf_size < REPORT_BYTES) begin
          o.read_status = STATUS_TOO_SMALL;
        end else begin
          o.read_status = STATUS_DELIVERED;
          o.read_press = rep_press;
          o.read_x = rep_x;
          o.read_y = rep_y;
          rep_pending = 1'b0;
        end
      end
      default: begin
      end
    endcase
    o.report_ready = rep_pending;
    return o;
  endfunction

  function automatic void check(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endfunction

  function automatic void queue_beat(mode_t m, logic ok, logic [COUNT_W-1:0] cnt,
                                     logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                     logic [BUF_W-1:0] bs);
    beat_t b;
    b.mode = m;
    b.now_ms = stim_ms;
    b.read_ok = ok;
    b.point_count = cnt;
    b.point_x = x;
    b.point_y = y;
    b.buf_size = bs;
    request_queue.push_back(b);
    queued++;
  endfunction

  function automatic logic [BUF_W-1:0] pick_buf();
    if ($urandom_range(0, 4) == 0) return BUF_W'($urandom_range(0, 5));
    return BUF_W'($urandom_range(6, 65535));
  endfunction

  function automatic void host_read();
    queue_beat(MODE_HOST, $urandom, $urandom, $urandom, $urandom, pick_buf());
  endfunction

  function automatic void idle_poll();
    queue_beat(MODE_IDLE, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Mostly whole gestures: presses spaced within the release delay, then a
  // quiet gap just past it. The rest is failure bursts and unrelated beats.
  function automatic void make_traffic(int n);
    int stop_at;
    int k;
    int r;
    int cap;
    stop_at = queued + n;
    while (queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          stim_ms += $urandom_range(0, cfg_delay);
          r = $urandom_range(0, 99);
          if (r < 80)
            queue_beat(MODE_TOUCH, 1'b1, $urandom_range(1, 5), $urandom, $urandom, $urandom);
          else if (r < 90)
            queue_beat(MODE_TOUCH, 1'b0, $urandom_range(0, 7), $urandom, $urandom, $urandom);
          else
            queue_beat(MODE_TOUCH, 1'b1, '0, $urandom, $urandom, $urandom);
          if ($urandom_range(0, 2) == 0) idle_poll();
          if ($urandom_range(0, 3) == 0) host_read();
        end
        if ($urandom_range(0, 4) == 0) begin
          stim_ms += cfg_delay;
          idle_poll();
          stim_ms += 1;
        end else begin
          stim_ms += cfg_delay + $urandom_range(1, 40);
        end
        if ($urandom_range(0, 3) == 0)
          queue_beat(MODE_TOUCH, $urandom, '0, $urandom, $urandom, $urandom);
        else
          idle_poll();
        host_read();
        k = $urandom_range(0, 4);
        repeat (k) begin
          stim_ms += $urandom_range(0, 3 * cfg_delay + 3);
          idle_poll();
        end
      end else if (r < 85) begin
        cap = int'(cfg_limit) + 2;
        if (cap > 40) cap = 40;
        k = $urandom_range(1, cap);
        repeat (k) begin
          stim_ms += $urandom_range(0, 5);
          queue_beat(MODE_TOUCH, 1'b0, $urandom_range(0, 7), $urandom, $urandom, $urandom);
        end
      end else begin
        stim_ms = $urandom;
        queue_beat(mode_t'($urandom_range(0, 3)), $urandom, $urandom_range(0, 7),
                   $urandom, $urandom, $urandom);
      end
    end
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RELEASE_DELAY: cfg_delay = value[DELAY_W-1:0];
      REG_POLL_MIN:      cfg_min = value[US_W-1:0];
      REG_POLL_MAX:      cfg_max = value[US_W-1:0];
      REG_POLL_HOLD:     cfg_hold = value[US_W-1:0];
      REG_FAIL_LIMIT:    cfg_limit = value[FAIL_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(int delay, int min_us, int max_us, int hold_us, int limit);
    write_reg(REG_RELEASE_DELAY, delay);
    write_reg(REG_POLL_MIN, min_us);
    write_reg(REG_POLL_MAX, max_us);
    write_reg(REG_POLL_HOLD, hold_us);
    write_reg(REG_FAIL_LIMIT, limit);
  endtask

  // Sampled on the falling edge so that a beat just taken from the queue
  // already shows on the valid line.
  task automatic drain();
    while (request_queue.size() != 0 || req.valid || awaited_outcomes.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    logic show;
    if (rst) begin
      req.valid <= 1'b0;
      pressed = 1'b0;
      last_touch_ms = '0;
      rep_press = 1'b0;
      rep_x = '0;
      rep_y = '0;
      rep_pending = 1'b0;
      poll_gap_us = POLL_MIN_RESET;
      fail_count = '0;
      last_x = '0;
      last_y = '0;
    end else begin
      if (req.valid && req.ready) awaited_outcomes.push_back(qualify(shown_beat));
      if (!req.valid || req.ready) begin
        show = 1'b0;
        if (request_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
          shown_beat = request_queue.pop_front();
          show = 1'b1;
          req.mode <= shown_beat.mode;
          req.now_ms <= shown_beat.now_ms;
          req.read_ok <= shown_beat.read_ok;
          req.point_count <= shown_beat.point_count;
          req.point_x <= shown_beat.point_x;
          req.point_y <= shown_beat.point_y;
          req.buf_size <= shown_beat.buf_size;
        end
        req.valid <= show;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result beat arrived with nothing outstanding");
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          check("sleep_us", want.sleep_us, rsp.sleep_us);
          check("wakeup", want.wakeup, rsp.wakeup);
          check("reinit_request", want.reinit_request, rsp.reinit_request);
          check("read_status", want.read_status, rsp.read_status);
          check("read_press", want.read_press, rsp.read_press);
          check("read_x", want.read_x, rsp.read_x);
          check("read_y", want.read_y, rsp.read_y);
          check("report_ready", want.report_ready, rsp.report_ready);
        end
      end
      rsp.ready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.mode = MODE_IDLE;
    req.now_ms = '0;
    req.read_ok = 1'b0;
    req.point_count = '0;
    req.point_x = '0;
    req.point_y = '0;
    req.buf_size = '0;
    rsp.ready = 1'b0;

    // Reset settings: back-off to the ceiling, overwrite of a pending press,
    // short host buffers, release on an idle poll and across the time wrap.
    stim_ms = 32'd0;
    queue_beat(MODE_HOST, 1'b0, '0, '0, '0, 16'd100);
    repeat (4) begin
      idle_poll();
      stim_ms += 1;
    end
    stim_ms = 32'd10;
    queue_beat(MODE_TOUCH, 1'b1, 3'd1, 16'hFFFF, 16'h0000, '0);
    queue_beat(MODE_HOST, 1'b0, '0, '0, '0, 16'd5);
    queue_beat(MODE_HOST, 1'b0, '0, '0, '0, 16'd0);
    stim_ms = 32'd12;
    queue_beat(MODE_TOUCH, 1'b1, 3'd5, 16'h0000, 16'hFFFF, 16'hFFFF);
    queue_beat(MODE_HOST, 1'b1, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    stim_ms = 32'd20;
    idle_poll();
    stim_ms = 32'd25;
    queue_beat(MODE_TOUCH, 1'b0, 3'd3, 16'h1234, 16'h4321, '0);
    stim_ms = 32'd30;
    queue_beat(MODE_TOUCH, 1'b1, 3'd0, 16'hAAAA, 16'h5555, '0);
    stim_ms = 32'd33;
    idle_poll();
    queue_beat(MODE_HOST, 1'b0, '0, '0, '0, 16'd6);
    stim_ms = 32'hFFFF_FFFF;
    queue_beat(MODE_NONE, 1'b1, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    stim_ms = 32'hFFFF_FFF0;
    queue_beat(MODE_TOUCH, 1'b1, 3'd7, 16'h8000, 16'h7FFF, '0);
    stim_ms = 32'h0000_0004;
    idle_poll();
    stim_ms = 32'h0000_0005;
    idle_poll();
    queue_beat(MODE_TOUCH, 1'b1, 3'd6, 16'h0F0F, 16'hF0F0, '0);
    queue_beat(MODE_HOST, 1'b0, '0, '0, '0, 16'd6);
    make_traffic(110);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    drain();

    set_config(0, 0, 65535, 0, 0);
    make_traffic(110);
    drain();

    set_config(1023, 65535, 1, 65535, 255);
    repeat (256) begin
      stim_ms += 1;
      queue_beat(MODE_TOUCH, 1'b0, $urandom_range(0, 7), $urandom, $urandom, $urandom);
    end
    make_traffic(110);
    drain();

    calm = 1'b1;
    set_config(1000, 1, 65535, 1, 1);
    make_traffic(110);
    drain();
    calm = 1'b0;

    repeat (4) begin
      set_config($urandom_range(0, 60), $urandom_range(1, 20000), $urandom_range(1, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 8));
      make_traffic(110);
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
